>>> hdl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// Console bus decode package
// Shared constants and the owner decode function for the bus decoder and its work RAM.
// ----------------------------------------------------------------------------
`default_nettype none
package cbd_pkg;
  localparam int WramAw = 16;
  localparam int FmAw = 9;
  localparam logic [2:0] OWN_ROM = 3'd0;
  localparam logic [2:0] OWN_Z80 = 3'd1;
  localparam logic [2:0] OWN_IO = 3'd2;
  localparam logic [2:0] OWN_VIDEO = 3'd3;
  localparam logic [2:0] OWN_WRAM = 3'd4;
  localparam logic [2:0] OWN_OPEN = 3'd5;
  localparam logic [1:0] DMA_NONE = 2'd0;
  localparam logic [1:0] DMA_FILL = 2'd1;
  localparam logic [1:0] DMA_COPY = 2'd2;
  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam logic [6:0] DMA_CYC_16 = 7'd64;
  localparam logic [6:0] DMA_CYC_8 = 7'd32;

  function automatic logic [2:0] decode_owner(input logic [23:0] a);
    if (a < 24'h400000) return OWN_ROM;
    if (a >= 24'hA04000 && a <= 24'hA04003) return OWN_IO;
    if (a >= 24'hA00000 && a <= 24'hA0FFFF) return OWN_Z80;
    if ((a >= 24'hA10000 && a <= 24'hA1001F) || (a >= 24'hA11100 && a <= 24'hA11201))
      return OWN_IO;
    if (a >= 24'hC00000 && a <= 24'hC0001F) return OWN_VIDEO;
    if (a >= 24'hFF0000) return OWN_WRAM;
    return OWN_OPEN;
  endfunction
endpackage
`default_nettype wire

>>> hdl/cbd_ram.sv
// ----------------------------------------------------------------------------
// Cleared byte RAM
// Simple dual-port RAM (one read port, one write port) with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module cbd_ram #(
  parameter int Aw = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [Aw-1:0] raddr,
  output logic      [7:0]    rdata,
  input  wire logic          we,
  input  wire logic [Aw-1:0] waddr,
  input  wire logic [7:0]    wdata,
  output logic               busy
);
  logic [7:0] mem [2**Aw];
  logic [Aw:0] clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (!clr[Aw]) begin
      clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clr[Aw]) begin
      mem[clr[Aw-1:0]] <= 8'd0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign busy = !clr[Aw];
endmodule
`default_nettype wire

>>> hdl/console_bus_decode_and_ports_unit.sv
// ----------------------------------------------------------------------------
// Console bus decode and ports unit
// Decodes one byte bus request per cycle, unless stalled, and keeps the port state.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/stall | command, address, write_data
//  out     | output    | out_valid/stall| read_data, owner, dma and z80 flags
//
// Work RAM and sound registers are read as a request enters stage 1, and the
// result is formed and written as it moves on to the output register. One
// request per cycle is sustained while the output is not stalled. After reset
// a clearing sweep zeroes work RAM (and the sound registers), during which
// in_stall is high. A stalled output holds; outside the sweep the input is
// stalled only when the output register is full and stalled.
`default_nettype none
module console_bus_decode_and_ports_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [23:0] address,
  input  wire logic [7:0]  write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  read_data,
  output logic      [2:0]  owner,
  output logic             dma_active,
  output logic      [1:0]  dma_kind,
  output logic             z80_running_out,
  output logic             z80_bus_held
);
  // Stage 1 holds the request while the memories read.
  logic        s1_valid;
  logic        s1_cmd;
  logic [23:0] s1_addr;
  logic [7:0]  s1_data;
  logic [2:0]  s1_own;
  logic        wram_busy, fm_busy;
  logic [7:0]  wram_q, fm_q;
  logic        adv, acc;

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv || wram_busy || fm_busy;
  assign acc = in_valid && !in_stall;

  // Small register state.
  logic [7:0]  io_bytes [32];
  logic [7:0]  video_regs [32];
  logic [15:0] video_status, video_data_latch, video_control_latch;
  logic [1:0]  dma_mode_reg;
  logic [6:0]  dma_cycles_left;
  logic [4:0]  dma_word_count;
  logic        dma_request_flag;
  logic [7:0]  fm_low, fm_high;
  logic [7:0]  tone_regs [8];
  logic [2:0]  tone_idx;
  logic        z80_booted, z80_run, z80_breq;

  // Sound register address from the latch as seen by the current request;
  // the latch written by the request in stage 1 is forwarded.
  logic [7:0] fm_low_fw, fm_high_fw;
  always_comb begin
    fm_low_fw = fm_low;
    fm_high_fw = fm_high;
    if (s1_valid && adv && s1_cmd != cbd_pkg::CMD_READ && s1_addr == 24'hA04000)
      fm_low_fw = s1_data;
    if (s1_valid && adv && s1_cmd != cbd_pkg::CMD_READ && s1_addr == 24'hA04002)
      fm_high_fw = s1_data;
  end

  logic [8:0] fm_raddr, fm_waddr;
  logic       fm_we, wram_we;
  assign fm_raddr = (address == 24'hA04003) ? {1'b1, fm_high_fw} : {1'b0, fm_low_fw};
  assign fm_waddr = (s1_addr == 24'hA04003) ? {1'b1, fm_high} : {1'b0, fm_low};
  assign fm_we = s1_valid && adv && s1_cmd != cbd_pkg::CMD_READ &&
                 (s1_addr == 24'hA04001 || s1_addr == 24'hA04003);
  assign wram_we = s1_valid && adv && s1_cmd != cbd_pkg::CMD_READ &&
                   s1_own == cbd_pkg::OWN_WRAM;

  // Memory read happens when the request enters stage 1; a write to the same
  // entry by the request leaving stage 1 is forwarded below.
  logic [cbd_pkg::WramAw-1:0] wram_raddr;
  assign wram_raddr = adv ? address[15:0] : s1_addr[15:0];
  logic [8:0] fm_ra;
  assign fm_ra = adv ? fm_raddr : fm_waddr;

  cbd_ram #(.Aw(cbd_pkg::WramAw)) u_wram (
    .clk, .rst, .raddr(wram_raddr), .rdata(wram_q), .we(wram_we),
    .waddr(s1_addr[15:0]), .wdata(s1_data), .busy(wram_busy));
  cbd_ram #(.Aw(cbd_pkg::FmAw)) u_fm (
    .clk, .rst, .raddr(fm_ra), .rdata(fm_q), .we(fm_we),
    .waddr(fm_waddr), .wdata(s1_data), .busy(fm_busy));

  // Forwarding of a write that lands in the same cycle as the read.
  logic       wram_fw, fm_fw;
  logic [7:0] fw_data;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wram_fw <= 1'b0;
      fm_fw <= 1'b0;
    end else if (adv) begin
      s1_valid <= acc;
      wram_fw <= wram_we && s1_addr[15:0] == address[15:0];
      fm_fw <= fm_we && fm_waddr == fm_raddr;
    end else begin
      wram_fw <= 1'b0;
      fm_fw <= 1'b0;
    end
    if (adv) begin
      s1_cmd <= command;
      s1_addr <= address;
      s1_data <= write_data;
      s1_own <= cbd_pkg::decode_owner(address);
      fw_data <= s1_data;
    end
  end

  logic [7:0] wram_rd, fm_rd;
  assign wram_rd = wram_fw ? fw_data : wram_q;
  assign fm_rd = fm_fw ? fw_data : fm_q;

  // Stage 2: read data and state update.
  logic [7:0]  rd;
  logic [15:0] vs_n, vdl_n, vcl_n;
  logic [1:0]  dm_n;
  logic [6:0]  dcl_n;
  logic [4:0]  dwc_n;
  logic        drf_n, run_n, breq_n, boot_n, vr_we;
  logic [4:0]  vr_idx;
  logic [7:0]  vr_val;
  logic [2:0]  ti_n;
  logic        t_we;
  logic [7:0]  t_val;
  always_comb begin
    rd = 8'd0;
    vs_n = video_status; vdl_n = video_data_latch; vcl_n = video_control_latch;
    dm_n = dma_mode_reg; dcl_n = dma_cycles_left; dwc_n = dma_word_count;
    drf_n = dma_request_flag; run_n = z80_run; breq_n = z80_breq; boot_n = z80_booted;
    vr_we = 1'b0; vr_idx = vcl_n[12:8]; vr_val = 8'd0;
    ti_n = tone_idx; t_we = 1'b0; t_val = 8'd0;
    if (s1_cmd == cbd_pkg::CMD_READ) begin
      case (s1_own)
        cbd_pkg::OWN_ROM: rd = 8'd0;
        cbd_pkg::OWN_Z80: rd = (z80_run && !z80_breq) ? 8'hFF : 8'h00;
        cbd_pkg::OWN_IO: begin
          if (s1_addr == 24'hA04000) rd = fm_low;
          else if (s1_addr == 24'hA04001 || s1_addr == 24'hA04003) rd = fm_rd;
          else if (s1_addr == 24'hA04002) rd = fm_high;
          else if (s1_addr == 24'hA11100) rd = {7'd0, z80_breq};
          else if (s1_addr == 24'hA11200) rd = {7'd0, z80_run};
          else rd = io_bytes[s1_addr[4:0]];
        end
        cbd_pkg::OWN_VIDEO: begin
          if (s1_addr <= 24'hC00003) begin
            rd = s1_addr[0] ? video_data_latch[7:0] : video_data_latch[15:8];
          end else begin
            rd = s1_addr[0] ? video_status[7:0] : video_status[15:8];
            if (!s1_addr[0]) vs_n[15] = 1'b0;
          end
        end
        cbd_pkg::OWN_WRAM: rd = wram_rd;
        default: rd = 8'hFF;
      endcase
    end else begin
      if (s1_own == cbd_pkg::OWN_IO) begin
        if (s1_addr == 24'hA11100) begin
          breq_n = s1_data[0];
          if (s1_data[0]) run_n = 1'b0;
          else if (z80_booted) run_n = 1'b1;
        end
        if (s1_addr == 24'hA11200) begin
          if (!s1_data[0]) run_n = 1'b0;
          else begin
            boot_n = 1'b1;
            if (!z80_breq) run_n = 1'b1;
          end
        end
      end
      if (s1_own == cbd_pkg::OWN_VIDEO) begin
        if (s1_addr == 24'hC00011) begin
          t_we = 1'b1;
          if (s1_data[7]) begin
            ti_n = s1_data[6:4];
            t_val = {tone_regs[s1_data[6:4]][7:4], s1_data[3:0]};
          end else begin
            t_val = {s1_data[3:0], tone_regs[tone_idx][3:0]};
          end
        end
        if (s1_addr <= 24'hC00003) begin
          if (s1_addr[0]) vdl_n[7:0] = s1_data;
          else vdl_n[15:8] = s1_data;
          vs_n[1] = 1'b0; vs_n[0] = 1'b1;
        end else if (!s1_addr[0]) begin
          vcl_n[15:8] = s1_data;
        end else begin
          vcl_n[7:0] = s1_data;
          if (vcl_n[15:14] == 2'b10) begin
            vr_we = 1'b1; vr_idx = vcl_n[12:8]; vr_val = vcl_n[7:0];
            if (vr_idx == 5'd23) begin
              dm_n = (vr_val[7:6] == 2'b10) ? cbd_pkg::DMA_FILL :
                     (vr_val[7:6] == 2'b11) ? cbd_pkg::DMA_COPY : cbd_pkg::DMA_NONE;
            end
            if (vr_idx == 5'd1) begin
              vs_n[3] = vr_val[6];
              if (vr_val[5]) begin
                if (dm_n == cbd_pkg::DMA_NONE) dm_n = cbd_pkg::DMA_COPY;
                dwc_n = 5'd16; dcl_n = cbd_pkg::DMA_CYC_16; drf_n = 1'b1;
              end
            end
          end else if (vcl_n[15:14] == 2'b01) begin
            vs_n = {1'b1, vs_n[14:2], 1'b1, 1'b0};
          end
        end
        if (s1_addr >= 24'hC00004 && s1_addr <= 24'hC00007 && s1_data[7]) begin
          drf_n = 1'b1;
          if (dm_n == cbd_pkg::DMA_NONE) dm_n = cbd_pkg::DMA_COPY;
          if (dcl_n == 7'd0) begin
            dwc_n = 5'd8; dcl_n = cbd_pkg::DMA_CYC_8;
          end
        end
      end
    end
  end

  logic wr_go;
  assign wr_go = s1_valid && adv && s1_cmd != cbd_pkg::CMD_READ;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      video_status <= 16'h0001; video_data_latch <= '0; video_control_latch <= '0;
      dma_mode_reg <= cbd_pkg::DMA_NONE; dma_cycles_left <= '0; dma_word_count <= '0;
      dma_request_flag <= 1'b0; fm_low <= '0; fm_high <= '0; tone_idx <= '0;
      z80_booted <= 1'b0; z80_run <= 1'b0; z80_breq <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        io_bytes[i] <= '0;
        video_regs[i] <= '0;
      end
      for (int i = 0; i < 8; i++) tone_regs[i] <= '0;
    end else if (adv) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        video_status <= vs_n; video_data_latch <= vdl_n; video_control_latch <= vcl_n;
        dma_mode_reg <= dm_n; dma_cycles_left <= dcl_n; dma_word_count <= dwc_n;
        dma_request_flag <= drf_n; z80_run <= run_n; z80_breq <= breq_n;
        z80_booted <= boot_n; tone_idx <= ti_n;
        if (t_we) tone_regs[ti_n] <= t_val;
        if (vr_we) video_regs[vr_idx] <= vr_val;
        read_data <= rd;
        owner <= s1_own;
        dma_active <= dm_n != cbd_pkg::DMA_NONE && dcl_n != 7'd0;
        dma_kind <= dm_n;
        z80_running_out <= run_n;
        z80_bus_held <= breq_n;
      end
      if (wr_go && s1_own == cbd_pkg::OWN_IO) begin
        io_bytes[s1_addr[4:0]] <= s1_data;
        if (s1_addr == 24'hA04000) fm_low <= s1_data;
        if (s1_addr == 24'hA04002) fm_high <= s1_data;
      end
    end
  end
endmodule
`default_nettype wire

>>> sim/console_bus_decode_and_ports_unit_test.sv
// ----------------------------------------------------------------------------
// Console bus decode and ports unit testbench
// Sends byte bus requests, predicts each result from a private model of the
// port state, and compares every result field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none
module console_bus_decode_and_ports_unit_test;

  localparam int CyclesPerWord = 4;
  localparam int CycleLimit = 1200000;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] owner;
    logic       dma_active;
    logic [1:0] dma_kind;
    logic       z80_running;
    logic       z80_held;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [23:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic [2:0]  owner;
  logic        dma_active;
  logic [1:0]  dma_kind;
  logic        z80_running_out;
  logic        z80_bus_held;

  console_bus_decode_and_ports_unit u_dut (
    .clk, .rst, .in_valid, .in_stall, .command, .address, .write_data,
    .out_valid, .out_stall, .read_data, .owner, .dma_active, .dma_kind,
    .z80_running_out, .z80_bus_held
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Private copy of the port state used to predict each result.
  logic [7:0]  m_wram [65536];
  logic [7:0]  m_io [32];
  logic [7:0]  m_vreg [32];
  logic [7:0]  m_fm [512];
  logic [7:0]  m_tone [8];
  logic [15:0] m_status, m_data_latch, m_ctrl_latch;
  logic [1:0]  m_dma_mode;
  logic [6:0]  m_dma_cycles;
  logic [4:0]  m_dma_words;
  logic        m_dma_req;
  logic [7:0]  m_fm_lo, m_fm_hi;
  logic [2:0]  m_tone_idx;
  logic        m_booted, m_run, m_busreq;

  bus_result_t expected_results[$];
  int          fail_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  task automatic clear_port_model();
    foreach (m_wram[i]) m_wram[i] = '0;
    foreach (m_io[i]) m_io[i] = '0;
    foreach (m_vreg[i]) m_vreg[i] = '0;
    foreach (m_fm[i]) m_fm[i] = '0;
    foreach (m_tone[i]) m_tone[i] = '0;
    m_status = 16'h0001;
    m_data_latch = '0;
    m_ctrl_latch = '0;
    m_dma_mode = cbd_pkg::DMA_NONE;
    m_dma_cycles = '0;
    m_dma_words = '0;
    m_dma_req = 1'b0;
    m_fm_lo = '0;
    m_fm_hi = '0;
    m_tone_idx = '0;
    m_booted = 1'b0;
    m_run = 1'b0;
    m_busreq = 1'b0;
  endtask

  function automatic logic [2:0] owner_of(input logic [23:0] a);
    if (a < 24'h400000) return cbd_pkg::OWN_ROM;
    if (a inside {[24'hA04000 : 24'hA04003]}) return cbd_pkg::OWN_IO;
    if (a inside {[24'hA00000 : 24'hA0FFFF]}) return cbd_pkg::OWN_Z80;
    if (a inside {[24'hA10000 : 24'hA1001F], [24'hA11100 : 24'hA11201]})
      return cbd_pkg::OWN_IO;
    if (a inside {[24'hC00000 : 24'hC0001F]}) return cbd_pkg::OWN_VIDEO;
    if (a >= 24'hFF0000) return cbd_pkg::OWN_WRAM;
    return cbd_pkg::OWN_OPEN;
  endfunction

  task automatic launch_dma(input logic [1:0] mode, input int words);
    int cyc;
    cyc = words * CyclesPerWord;
    m_dma_mode = mode;
    m_dma_words = words[4:0];
    m_dma_cycles = (cyc > 127) ? 7'd127 : cyc[6:0];
    m_dma_req = 1'b1;
  endtask

  task automatic apply_control_word(input logic [15:0] cw);
    logic [4:0] idx;
    logic [7:0] val;
    idx = cw[12:8];
    val = cw[7:0];
    if (cw[15:14] == 2'b10) begin
      m_vreg[idx] = val;
      if (idx == 5'd23) begin
        m_dma_mode = (val[7:6] == 2'b10) ? cbd_pkg::DMA_FILL :
                     (val[7:6] == 2'b11) ? cbd_pkg::DMA_COPY : cbd_pkg::DMA_NONE;
      end
      if (idx == 5'd1) begin
        m_status[3] = val[6];
        if (val[5]) begin
          if (m_dma_mode == cbd_pkg::DMA_NONE) m_dma_mode = cbd_pkg::DMA_COPY;
          launch_dma(m_dma_mode, 16);
        end
      end
    end else if (cw[15:14] == 2'b01) begin
      m_status = ((m_status | 16'h8000) & 16'hFFFE) | 16'h0002;
    end
  endtask

  task automatic write_tone(input logic [7:0] v);
    if (v[7]) begin
      m_tone_idx = v[6:4];
      m_tone[m_tone_idx] = {m_tone[m_tone_idx][7:4], v[3:0]};
    end else begin
      m_tone[m_tone_idx] = {v[3:0], m_tone[m_tone_idx][3:0]};
    end
  endtask

  // Applies one bus access to the model and returns the result it causes.
  task automatic predict_access(input logic cmd, input logic [23:0] a, input logic [7:0] v,
                                output bus_result_t r);
    logic [2:0] own;
    logic [7:0] rd;
    own = owner_of(a);
    rd = '0;
    if (cmd == cbd_pkg::CMD_READ) begin
      case (own)
        cbd_pkg::OWN_ROM: rd = '0;
        cbd_pkg::OWN_Z80: rd = (m_run && !m_busreq) ? 8'hFF : 8'h00;
        cbd_pkg::OWN_IO: begin
          if (a == 24'hA04000) rd = m_fm_lo;
          else if (a == 24'hA04001) rd = m_fm[{1'b0, m_fm_lo}];
          else if (a == 24'hA04002) rd = m_fm_hi;
          else if (a == 24'hA04003) rd = m_fm[{1'b1, m_fm_hi}];
          else if (a == 24'hA11100) rd = {7'd0, m_busreq};
          else if (a == 24'hA11200) rd = {7'd0, m_run};
          else rd = m_io[a[4:0]];
        end
        cbd_pkg::OWN_VIDEO: begin
          if (a <= 24'hC00003) begin
            rd = a[0] ? m_data_latch[7:0] : m_data_latch[15:8];
          end else begin
            rd = a[0] ? m_status[7:0] : m_status[15:8];
            if (!a[0]) m_status[15] = 1'b0;
          end
        end
        cbd_pkg::OWN_WRAM: rd = m_wram[a[15:0]];
        default: rd = 8'hFF;
      endcase
    end else begin
      case (own)
        cbd_pkg::OWN_IO: begin
          m_io[a[4:0]] = v;
          if (a == 24'hA04000) m_fm_lo = v;
          if (a == 24'hA04001) m_fm[{1'b0, m_fm_lo}] = v;
          if (a == 24'hA04002) m_fm_hi = v;
          if (a == 24'hA04003) m_fm[{1'b1, m_fm_hi}] = v;
          if (a == 24'hA11100) begin
            m_busreq = v[0];
            if (m_busreq) m_run = 1'b0;
            else if (m_booted) m_run = 1'b1;
          end
          if (a == 24'hA11200) begin
            if (!v[0]) begin
              m_run = 1'b0;
            end else begin
              m_booted = 1'b1;
              if (!m_busreq) m_run = 1'b1;
            end
          end
        end
        cbd_pkg::OWN_VIDEO: begin
          if (a == 24'hC00011) write_tone(v);
          if (a <= 24'hC00003) begin
            if (!a[0]) m_data_latch[15:8] = v;
            else m_data_latch[7:0] = v;
            m_status = (m_status & 16'hFFFD) | 16'h0001;
          end else if (!a[0]) begin
            m_ctrl_latch[15:8] = v;
          end else begin
            m_ctrl_latch[7:0] = v;
            apply_control_word(m_ctrl_latch);
          end
          if (a inside {[24'hC00004 : 24'hC00007]} && v[7]) begin
            m_dma_req = 1'b1;
            if (m_dma_mode == cbd_pkg::DMA_NONE) m_dma_mode = cbd_pkg::DMA_COPY;
            if (m_dma_cycles == 0) launch_dma(m_dma_mode, 8);
          end
        end
        cbd_pkg::OWN_WRAM: m_wram[a[15:0]] = v;
        default: ;
      endcase
    end
    r.read_data = rd;
    r.owner = own;
    r.dma_active = (m_dma_mode != cbd_pkg::DMA_NONE) && (m_dma_cycles != 0);
    r.dma_kind = m_dma_mode;
    r.z80_running = m_run;
    r.z80_held = m_busreq;
  endtask

  // Drives one request at the falling edge and holds it until accepted. The
  // valid stays high afterwards so that requests can follow back to back; an
  // idle cycle or a drain drops it.
  task automatic send_request(input logic cmd, input logic [23:0] a, input logic [7:0] v);
    bus_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    address <= a;
    write_data <= v;
    do @(posedge clk); while (in_stall);
    predict_access(cmd, a, v, r);
    expected_results = {expected_results, r};
    sent_count++;
    @(negedge clk);
  endtask

  // Receiver stall and result checking.
  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    bus_result_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (read_data !== want.read_data) begin
          $error("read_data expected %h got %h", want.read_data, read_data);
          fail_count++;
        end
        if (owner !== want.owner) begin
          $error("owner expected %0d got %0d", want.owner, owner);
          fail_count++;
        end
        if (dma_active !== want.dma_active) begin
          $error("dma_active expected %b got %b", want.dma_active, dma_active);
          fail_count++;
        end
        if (dma_kind !== want.dma_kind) begin
          $error("dma_kind expected %0d got %0d", want.dma_kind, dma_kind);
          fail_count++;
        end
        if (z80_running_out !== want.z80_running) begin
          $error("z80_running_out expected %b got %b", want.z80_running, z80_running_out);
          fail_count++;
        end
        if (z80_bus_held !== want.z80_held) begin
          $error("z80_bus_held expected %b got %b", want.z80_held, z80_bus_held);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Address picks weighted toward the interesting windows.
  function automatic logic [23:0] pick_address();
    case ($urandom_range(11))
      0: return 24'($urandom_range(24'h3FFFFF));
      1: return 24'(24'hA04000 + $urandom_range(3));
      2: return 24'(24'hA00000 + $urandom_range(16'hFFFF));
      3: return 24'(24'hA10000 + $urandom_range(31));
      4: return $urandom_range(1) ? 24'hA11100 : 24'hA11200;
      5: return 24'(24'hA11100 + $urandom_range(24'h101));
      6, 7: return 24'(24'hC00000 + $urandom_range(31));
      8, 9: return 24'(24'hFF0000 + $urandom_range(15));
      10: return 24'(24'hFF0000 + $urandom_range(16'hFFFF));
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic test_directed_extremes();
    send_request(cbd_pkg::CMD_READ, 24'h000000, 8'h00);
    send_request(cbd_pkg::CMD_WRITE, 24'h3FFFFF, 8'hFF);
    send_request(cbd_pkg::CMD_WRITE, 24'hFFFFFF, 8'hFF);
    send_request(cbd_pkg::CMD_READ, 24'hFFFFFF, 8'h00);
    send_request(cbd_pkg::CMD_READ, 24'h800000, 8'h00);
    send_request(cbd_pkg::CMD_WRITE, 24'hA04000, 8'h2A);
    send_request(cbd_pkg::CMD_WRITE, 24'hA04001, 8'h5C);
    send_request(cbd_pkg::CMD_READ, 24'hA04001, 8'h00);
    send_request(cbd_pkg::CMD_WRITE, 24'hA04002, 8'hFF);
    send_request(cbd_pkg::CMD_WRITE, 24'hA04003, 8'h81);
    send_request(cbd_pkg::CMD_READ, 24'hA04003, 8'h00);
    // Boot the Z80, then take and release its bus.
    send_request(cbd_pkg::CMD_WRITE, 24'hA11200, 8'h01);
    send_request(cbd_pkg::CMD_READ, 24'hA00010, 8'h00);
    send_request(cbd_pkg::CMD_WRITE, 24'hA11100, 8'h01);
    send_request(cbd_pkg::CMD_READ, 24'hA0FFFF, 8'h00);
    send_request(cbd_pkg::CMD_WRITE, 24'hA11100, 8'h00);
    // Control word writing register 1 with DMA start, then a set-status word.
    send_request(cbd_pkg::CMD_WRITE, 24'hC00004, 8'h81);
    send_request(cbd_pkg::CMD_WRITE, 24'hC00005, 8'h60);
    send_request(cbd_pkg::CMD_WRITE, 24'hC00004, 8'h40);
    send_request(cbd_pkg::CMD_WRITE, 24'hC00005, 8'h00);
    // Status high byte read clears the top bit; the second read shows it.
    send_request(cbd_pkg::CMD_READ, 24'hC00004, 8'h00);
    send_request(cbd_pkg::CMD_READ, 24'hC00004, 8'h00);
    send_request(cbd_pkg::CMD_WRITE, 24'hC00011, 8'hB5);
    send_request(cbd_pkg::CMD_WRITE, 24'hC00011, 8'h0A);
    send_request(cbd_pkg::CMD_READ, 24'hC00001, 8'h00);
  endtask

  task automatic test_random_mix(input int count);
    logic [23:0] a;
    repeat (count) begin
      a = pick_address();
      send_request(1'($urandom_range(1)), a, 8'($urandom_range(255)));
    end
  endtask

  // Well-formed control word pairs with random content, half aimed at the DMA registers.
  task automatic test_video_sequences(input int count);
    logic [7:0] hi;
    repeat (count) begin
      case ($urandom_range(3))
        0: hi = 8'h97;
        1: hi = 8'h81;
        2: hi = 8'(8'h40 | $urandom_range(63));
        default: hi = 8'($urandom_range(255));
      endcase
      send_request(cbd_pkg::CMD_WRITE, 24'(24'hC00004 + 2 * $urandom_range(1)), hi);
      send_request(cbd_pkg::CMD_WRITE, 24'(24'hC00005 + 2 * $urandom_range(1)),
                   8'($urandom_range(255)));
      send_request(cbd_pkg::CMD_READ, 24'(24'hC00004 + $urandom_range(3)), 8'h00);
    end
  endtask

  initial begin
    clear_port_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    send_idle_pct = 23;
    recv_idle_pct = 68;
    test_random_mix(120);
    test_video_sequences(25);
    // Hold off the sender until the pipeline is empty.
    wait_results_drained();
    send_idle_pct = 68;
    recv_idle_pct = 23;
    test_random_mix(120);
    test_video_sequences(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(185);
    wait_results_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d of %0d bus requests across all decode windows,", checked_count,
             sent_count);
    $display("video control words, DMA starts, sound and Z80 port traffic.");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> console_bus_decode_and_ports_unit.f
hdl/cbd_pkg.sv
hdl/cbd_ram.sv
hdl/console_bus_decode_and_ports_unit.sv
sim/console_bus_decode_and_ports_unit_test.sv
